@@ rtl/scanline_event_and_hv_irq_timer_assert.svh @@
// assertion macros used by slirq_core
`ifndef SCANLINE_EVENT_AND_HV_IRQ_TIMER_ASSERT_SVH
`define SCANLINE_EVENT_AND_HV_IRQ_TIMER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SLIRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SLIRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/slirq_pkg.sv @@
`default_nettype none
package slirq_pkg;

  localparam int unsigned POS_W = 9;
  localparam int unsigned FC_W  = 4;

  localparam logic [POS_W-1:0] DMA_STEP_DOT        = 9'd278;
  localparam logic [POS_W-1:0] VISIBLE_LINES_RESET = 9'd224;
  localparam logic [FC_W-1:0]  FRAME_COUNTER_MAX   = 4'd15;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_V_IRQ_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_H_IRQ_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_LINE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_DOT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_LINES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_JOYPAD   = 3'd6;

  typedef struct packed {
    logic [POS_W-1:0] dot;
    logic [POS_W-1:0] line;
    logic             line_wrapped;
    logic             irq_masked;
    logic             cpu_stopped;
  } slirq_in_t;

  typedef struct packed {
    logic irq_fire;
    logic irq_flag;
    logic frame_start;
    logic refresh;
    logic joypad_read;
    logic render_line;
    logic dma_step;
  } slirq_out_t;

  typedef struct packed {
    logic             v_irq_enable;
    logic             h_irq_enable;
    logic [POS_W-1:0] irq_line;
    logic [POS_W-1:0] irq_dot;
    logic [POS_W-1:0] visible_lines;
    logic [FC_W-1:0]  skip_count;
    logic             auto_joypad;
  } slirq_cfg_t;

endpackage
`default_nettype wire

@@ rtl/slirq_cfg.sv @@
`default_nettype none
module slirq_cfg
  import slirq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output slirq_cfg_t                 cfg
);

  slirq_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_V_IRQ_ENABLE:  cfg_nxt.v_irq_enable  = wr_data[0];
        CFG_H_IRQ_ENABLE:  cfg_nxt.h_irq_enable  = wr_data[0];
        CFG_IRQ_LINE:      cfg_nxt.irq_line      = wr_data[POS_W-1:0];
        CFG_IRQ_DOT:       cfg_nxt.irq_dot       = wr_data[POS_W-1:0];
        CFG_VISIBLE_LINES: cfg_nxt.visible_lines = wr_data[POS_W-1:0];
        CFG_SKIP_COUNT:    cfg_nxt.skip_count    = wr_data[FC_W-1:0];
        CFG_AUTO_JOYPAD:   cfg_nxt.auto_joypad   = wr_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{visible_lines: VISIBLE_LINES_RESET, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/slirq_core.sv @@
`default_nettype none
module slirq_core
  import slirq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire slirq_in_t  item,
  input  wire slirq_cfg_t cfg,
  output slirq_out_t      res
);

  logic            dma_done_r, dma_done_nxt;
  logic            h_done_r, h_done_nxt;
  logic            v_done_r, v_done_nxt;
  logic            irq_status_r, irq_status_nxt;
  logic [FC_W-1:0] fc_r, fc_nxt;

  logic            at_top, at_refresh, at_joy, in_visible;
  logic [FC_W-1:0] fc_inc;
  logic            dma_eff, h_eff, v_eff;
  logic            v_hit, h_hit, fire, dma;

  always_comb begin
    at_top     = item.line == '0;
    at_refresh = item.line == cfg.visible_lines;
    // joypad line may sit one past the 9-bit range
    at_joy     = {1'b0, item.line} == ({1'b0, cfg.visible_lines} + 10'd1);
    in_visible = !at_top && (item.line < cfg.visible_lines);

    fc_inc = (fc_r < FRAME_COUNTER_MAX) ? fc_r + 4'd1 : fc_r;
    fc_nxt = fc_r;
    if (item.line_wrapped && at_refresh) begin
      fc_nxt = (fc_inc >= cfg.skip_count) ? '0 : fc_inc;
    end

    // per-line marks rearm on a wrap, the vertical mark only at the frame top
    dma_eff = item.line_wrapped ? 1'b0 : dma_done_r;
    h_eff   = item.line_wrapped ? 1'b0 : h_done_r;
    v_eff   = (item.line_wrapped && at_top) ? 1'b0 : v_done_r;

    dma          = (item.dot >= DMA_STEP_DOT) && !dma_eff;
    dma_done_nxt = dma_eff || dma;

    v_hit = (item.line == cfg.irq_line) && !v_eff;
    h_hit = (item.dot >= cfg.irq_dot) && !h_eff;
    fire  = 1'b0;
    h_done_nxt = h_eff;
    v_done_nxt = v_eff;
    if (!item.cpu_stopped && !item.irq_masked) begin
      if (cfg.v_irq_enable && cfg.h_irq_enable) begin
        fire = v_hit && h_hit;
        if (fire) begin
          h_done_nxt = 1'b1;
          v_done_nxt = 1'b1;
        end
      end else if (cfg.v_irq_enable) begin
        fire = v_hit;
        if (fire) begin
          v_done_nxt = 1'b1;
        end
      end else if (cfg.h_irq_enable) begin
        fire = h_hit;
        if (fire) begin
          h_done_nxt = 1'b1;
        end
      end
    end
    irq_status_nxt = irq_status_r || fire;

    res.irq_fire    = fire;
    res.irq_flag    = irq_status_nxt;
    res.frame_start = item.line_wrapped && at_top;
    res.refresh     = item.line_wrapped && at_refresh && (fc_r == '0);
    res.joypad_read = item.line_wrapped && at_joy && cfg.auto_joypad;
    res.render_line = item.line_wrapped && in_visible &&
                      ((cfg.skip_count == '0) || (fc_nxt == '0));
    res.dma_step    = dma;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dma_done_r   <= 1'b0;
      h_done_r     <= 1'b0;
      v_done_r     <= 1'b0;
      irq_status_r <= 1'b0;
      fc_r         <= '0;
    end else if (adv) begin
      dma_done_r   <= dma_done_nxt;
      h_done_r     <= h_done_nxt;
      v_done_r     <= v_done_nxt;
      irq_status_r <= irq_status_nxt;
      fc_r         <= fc_nxt;
    end
  end

`include "scanline_event_and_hv_irq_timer_assert.svh"

  `SLIRQ_ASSERT_NEXT(a_dma_marks_line, adv && res.dma_step, dma_done_r, "dma mark not set")
  `SLIRQ_ASSERT_NEXT(a_fire_sets_flag, adv && res.irq_fire, irq_status_r, "irq flag not set")
  `SLIRQ_ASSERT_NEXT(a_flag_sticky, irq_status_r, irq_status_r, "irq flag cleared")
  `SLIRQ_ASSERT_NOW(a_no_fire_stopped, item.cpu_stopped || item.irq_masked, !res.irq_fire, "irq while blocked")

endmodule
`default_nettype wire

@@ rtl/scanline_event_and_hv_irq_timer.sv @@
`default_nettype none
// Scanline event and H/V interrupt timer. Each beam tick presented on the
// input channel yields one result item with the line events, the per-line
// DMA step and the interrupt request and sticky flag. Throughput is one
// item per clock while the output is not stalled: an input register feeds the
// event and interrupt logic, whose result lands in the output register in
// the same cycle that the per-line and per-frame marks update, so the next
// tick is processed right behind it. Configuration writes are always ready
// and take effect on the following clock; write them only while idle.
module scanline_event_and_hv_irq_timer
  import slirq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire slirq_in_t             in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output slirq_out_t                 out_item,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  slirq_cfg_t cfg;
  slirq_in_t  s1_item_r;
  logic       s1_valid_r;
  slirq_out_t res;
  slirq_out_t s2_item_r;
  logic       s2_valid_r;
  logic       s2_load, adv, in_acc;

  assign cfg_ready = 1'b1;

  slirq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // output register frees when empty or being drained
  assign s2_load  = !s2_valid_r || !out_stall;
  assign adv      = s1_valid_r && s2_load;
  assign in_stall = s1_valid_r && !s2_load;
  assign in_acc   = in_valid && !in_stall;

  slirq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      s2_item_r <= res;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_item  = s2_item_r;

endmodule
`default_nettype wire

@@ test/scanline_event_and_hv_irq_timer_test.sv @@
`timescale 1ns / 1ps

module scanline_event_and_hv_irq_timer_test;
  import slirq_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  slirq_in_t             in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  slirq_out_t            out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  scanline_event_and_hv_irq_timer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // timer state as the block should hold it
  slirq_cfg_t  shadow_cfg;
  logic        beam_dma_done;
  logic        beam_h_done;
  logic        beam_v_done;
  logic        beam_irq_flag;
  logic [3:0]  beam_frames;

  slirq_out_t  pending_events[$];
  int          mismatches = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;

  string       event_field [7] = '{"irq_fire", "irq_flag", "frame_start", "refresh",
                                   "joypad_read", "render_line", "dma_step"};

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    int unsigned           reg_val;
    slirq_in_t             tick;
    bit                    known;
    slirq_out_t            known_out;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic slirq_out_t predict_beam_tick(slirq_in_t t);
    slirq_out_t r;
    logic       v_hit;
    logic       h_hit;
    r = '0;
    if (t.line_wrapped) begin
      beam_dma_done = 1'b0;
      beam_h_done = 1'b0;
      if (t.line == '0) begin
        beam_v_done = 1'b0;
        r.frame_start = 1'b1;
      end
      if (t.line == shadow_cfg.visible_lines) begin
        if (beam_frames == '0) r.refresh = 1'b1;
        if (beam_frames < FRAME_COUNTER_MAX) beam_frames = beam_frames + 4'd1;
        if (beam_frames >= shadow_cfg.skip_count) beam_frames = '0;
      end
      // joypad line may be 512, out of reach of a 9-bit line
      if ({1'b0, t.line} == {1'b0, shadow_cfg.visible_lines} + 10'd1 &&
          shadow_cfg.auto_joypad)
        r.joypad_read = 1'b1;
      if (t.line != '0 && t.line < shadow_cfg.visible_lines &&
          (shadow_cfg.skip_count == '0 || beam_frames == '0))
        r.render_line = 1'b1;
    end
    if (t.dot >= DMA_STEP_DOT && !beam_dma_done) begin
      r.dma_step = 1'b1;
      beam_dma_done = 1'b1;
    end
    if (!t.cpu_stopped && !t.irq_masked) begin
      v_hit = (t.line == shadow_cfg.irq_line) && !beam_v_done;
      h_hit = (t.dot >= shadow_cfg.irq_dot) && !beam_h_done;
      if (shadow_cfg.v_irq_enable && shadow_cfg.h_irq_enable) begin
        if (v_hit && h_hit) begin
          beam_v_done = 1'b1;
          beam_h_done = 1'b1;
          r.irq_fire = 1'b1;
        end
      end else if (shadow_cfg.v_irq_enable) begin
        if (v_hit) begin
          beam_v_done = 1'b1;
          r.irq_fire = 1'b1;
        end
      end else if (shadow_cfg.h_irq_enable) begin
        if (h_hit) begin
          beam_h_done = 1'b1;
          r.irq_fire = 1'b1;
        end
      end
      if (r.irq_fire) beam_irq_flag = 1'b1;
    end
    r.irq_flag = beam_irq_flag;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    slirq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("item %b with nothing pending", out_item));
      end else begin
        want = pending_events.pop_front();
        for (int b = 0; b < 7; b++) begin
          if (out_item[6-b] !== want[6-b])
            note_mismatch($sformatf("%s got %b want %b", event_field[b],
                                    out_item[6-b], want[6-b]));
        end
      end
    end
  end

  // result-side backpressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // all driving tasks start and end just after a falling edge
  task automatic send_tick(slirq_in_t t, bit known, slirq_out_t known_out);
    slirq_out_t pred;
    in_item <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = predict_beam_tick(t);
    pending_events.push_back(known ? known_out : pred);
    @(negedge clk);
  endtask

  task automatic idle_in(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_V_IRQ_ENABLE:  shadow_cfg.v_irq_enable = val[0];
      CFG_H_IRQ_ENABLE:  shadow_cfg.h_irq_enable = val[0];
      CFG_IRQ_LINE:      shadow_cfg.irq_line = val[POS_W-1:0];
      CFG_IRQ_DOT:       shadow_cfg.irq_dot = val[POS_W-1:0];
      CFG_VISIBLE_LINES: shadow_cfg.visible_lines = val[POS_W-1:0];
      CFG_SKIP_COUNT:    shadow_cfg.skip_count = val[FC_W-1:0];
      CFG_AUTO_JOYPAD:   shadow_cfg.auto_joypad = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void plan_tick(int d, int l, bit w, bit m, bit s,
                                    bit known = 1'b0, slirq_out_t o = '0);
    plan_row_t row;
    row = '{default: '0};
    row.tick.dot = d[POS_W-1:0];
    row.tick.line = l[POS_W-1:0];
    row.tick.line_wrapped = w;
    row.tick.irq_masked = m;
    row.tick.cpu_stopped = s;
    row.known = known;
    row.known_out = o;
    plan.push_back(row);
  endfunction

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    plan_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endfunction

  initial begin
    slirq_in_t   t;
    int unsigned vis;
    int unsigned frame_lines;
    int unsigned line_len;
    int unsigned tick_dot;
    int unsigned tick_line;
    int unsigned pick;

    shadow_cfg = '0;
    shadow_cfg.visible_lines = VISIBLE_LINES_RESET;
    beam_dma_done = 1'b0;
    beam_h_done = 1'b0;
    beam_v_done = 1'b0;
    beam_irq_flag = 1'b0;
    beam_frames = '0;

    // field order: fire flag frame_start refresh joypad render dma
    plan_tick(0, 0, 1, 0, 0, 1, 7'b0010000);
    plan_tick(511, 511, 0, 1, 1, 1, 7'b0000001);   // dma step while stopped
    plan_tick(277, 1, 1, 0, 0, 1, 7'b0000010);
    plan_tick(278, 1, 0, 0, 0, 1, 7'b0000001);
    plan_tick(300, 1, 0, 0, 0, 1, 7'b0000000);
    plan_tick(0, 224, 1, 0, 0, 1, 7'b0001000);
    plan_tick(0, 225, 1, 0, 0, 1, 7'b0000000);
    plan_write(CFG_AUTO_JOYPAD, 1);
    plan_write(CFG_SKIP_COUNT, 2);
    plan_tick(0, 225, 1, 0, 0, 1, 7'b0000100);
    // frame skip counting
    plan_tick(0, 224, 1, 0, 0);
    plan_tick(0, 5, 1, 0, 0);
    plan_tick(0, 224, 1, 0, 0);
    plan_tick(0, 5, 1, 0, 0);
    // v-only mode, masked and stopped first, no joypad at line 512
    plan_write(CFG_SKIP_COUNT, 15);
    plan_write(CFG_VISIBLE_LINES, 511);
    plan_write(CFG_IRQ_LINE, 511);
    plan_write(CFG_V_IRQ_ENABLE, 1);
    plan_tick(0, 511, 1, 1, 0);
    plan_tick(5, 511, 0, 0, 1);
    plan_tick(10, 511, 0, 0, 0);
    plan_tick(20, 511, 0, 0, 0);
    plan_tick(0, 0, 1, 0, 0);
    // h+v mode
    plan_write(CFG_H_IRQ_ENABLE, 1);
    plan_write(CFG_IRQ_LINE, 3);
    plan_write(CFG_IRQ_DOT, 511);
    plan_write(CFG_VISIBLE_LINES, 0);
    plan_write(CFG_SKIP_COUNT, 0);
    plan_tick(510, 3, 1, 0, 0);
    plan_tick(511, 3, 0, 0, 0);
    plan_tick(511, 3, 0, 0, 0);
    // h-only mode
    plan_write(CFG_V_IRQ_ENABLE, 0);
    plan_write(CFG_IRQ_DOT, 0);
    plan_tick(0, 4, 1, 0, 0);
    plan_tick(0, 4, 0, 0, 0);
    plan_tick(0, 1, 1, 0, 0);
    plan_tick(0, 0, 1, 0, 0);
    plan_tick(511, 511, 1, 1, 1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_tick(plan[i].tick, plan[i].known, plan[i].known_out);
      end
    end

    for (int phase = 0; phase < 10; phase++) begin
      // every phase starts from an idle block
      settle();
      calm = (phase == 3 || phase == 9);

      pick = $urandom_range(0, 9);
      if (pick == 0) vis = 0;
      else if (pick == 1) vis = 511;
      else if (pick == 2) vis = 224;
      else vis = $urandom_range(1, 6);
      frame_lines = vis + $urandom_range(2, 4);
      if (frame_lines > 512) frame_lines = 512;
      line_len = ($urandom_range(0, 1) == 0) ? 341 : 512;

      write_reg(CFG_V_IRQ_ENABLE, $urandom_range(0, 1));
      write_reg(CFG_H_IRQ_ENABLE, $urandom_range(0, 1));
      pick = $urandom_range(0, 7);
      write_reg(CFG_IRQ_LINE, (pick == 0) ? 511 : (pick == 1) ? 0 :
                $urandom_range(0, frame_lines - 1));
      pick = $urandom_range(0, 7);
      write_reg(CFG_IRQ_DOT, (pick == 0) ? 0 : (pick == 1) ? 511 :
                $urandom_range(0, 511));
      write_reg(CFG_VISIBLE_LINES, vis);
      pick = $urandom_range(0, 7);
      write_reg(CFG_SKIP_COUNT, (pick == 0) ? 15 : (pick == 1) ? 0 :
                $urandom_range(0, 4));
      write_reg(CFG_AUTO_JOYPAD, $urandom_range(0, 1));

      tick_line = (vis > 8) ? vis - 2 : 0;
      tick_dot = 0;
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(0, 6) == 0) begin
          // noise: any field value, wraps out of order
          t.dot = POS_W'($urandom_range(0, 511));
          t.line = POS_W'($urandom_range(0, 511));
          t.line_wrapped = 1'($urandom_range(0, 1));
          t.irq_masked = 1'($urandom_range(0, 1));
          t.cpu_stopped = 1'($urandom_range(0, 1));
        end else begin
          t.line_wrapped = 1'b0;
          tick_dot = tick_dot + $urandom_range(1, 160);
          if (tick_dot >= line_len) begin
            tick_dot = $urandom_range(0, 3);
            tick_line = (tick_line + 1) % frame_lines;
            t.line_wrapped = 1'b1;
          end
          t.dot = tick_dot[POS_W-1:0];
          t.line = tick_line[POS_W-1:0];
          t.irq_masked = ($urandom_range(0, 7) == 0);
          t.cpu_stopped = ($urandom_range(0, 7) == 0);
        end
        if (!calm && $urandom_range(0, 5) == 0) idle_in($urandom_range(1, 13));
        send_tick(t, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/slirq_pkg.sv
rtl/slirq_cfg.sv
rtl/slirq_core.sv
rtl/scanline_event_and_hv_irq_timer.sv
test/scanline_event_and_hv_irq_timer_test.sv
